// ===== design/two_class_fifo_oldest_first_defines.svh =====
// Assertion macros for the two-class FIFO.
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_DEFINES_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_DEFINES_SVH

// Clocked check, disabled while reset is asserted.
`define TCF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define TCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/tcf_pkg.sv =====
`timescale 1ns / 1ps

package tcf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW          = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 32;
    localparam int STAMP_W     = 16;

    // func codes
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // take_mode codes
    localparam logic [1:0] MODE_ANY = 2'd0;
    localparam logic [1:0] MODE_A   = 2'd1;
    localparam logic [1:0] MODE_B   = 2'd2;

    // status codes
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DEQUEUED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    id;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic               have;
        logic               full;
        logic [STAMP_W-1:0] head_stamp;
        logic [ID_W-1:0]    head_id;
    } t_q_stat;

endpackage

// ===== design/tcf_queue.sv =====
`timescale 1ns / 1ps

module tcf_queue import tcf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_q_ctrl            i_ctrl,
    input  logic [ID_W-1:0]    i_id,
    input  logic [STAMP_W-1:0] i_stamp,
    output t_q_stat            o_stat
);

    t_entry        r_store [QUEUE_DEPTH];
    logic [QW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [QW-1:0] n_head;
    logic [FW-1:0] n_fill;

    logic [FW:0]   w_sum;
    logic [FW:0]   w_tail_full;
    logic [QW-1:0] w_tail;

    // tail = (head + fill) mod depth; the sum stays below twice the depth
    assign w_sum       = (FW+1)'(r_head) + (FW+1)'(r_fill);
    assign w_tail_full = (w_sum >= (FW+1)'(QUEUE_DEPTH)) ? w_sum - (FW+1)'(QUEUE_DEPTH)
                                                         : w_sum;
    assign w_tail      = w_tail_full[QW-1:0];

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_ctrl.push) begin
            n_fill = r_fill + 1'b1;
        end else if (i_ctrl.pop) begin
            n_fill = r_fill - 1'b1;
            n_head = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_store[w_tail] <= '{stamp: i_stamp, id: i_id};
        end
    end

    assign o_stat.have       = (r_fill != '0);
    assign o_stat.full       = (r_fill == FW'(QUEUE_DEPTH));
    assign o_stat.head_stamp = r_store[r_head].stamp;
    assign o_stat.head_id    = r_store[r_head].id;

endmodule

// ===== design/tcf_select.sv =====
`timescale 1ns / 1ps

module tcf_select import tcf_pkg::*; (
    input  logic            i_go,
    input  logic            i_func,
    input  logic [ID_W-1:0] i_id,
    input  logic [1:0]      i_mode,
    input  t_q_stat         i_stat_a,
    input  t_q_stat         i_stat_b,
    output t_q_ctrl         o_ctrl_a,
    output t_q_ctrl         o_ctrl_b,
    output logic [1:0]      o_status,
    output logic [ID_W-1:0] o_taken
);

    logic               w_to_a;
    logic [STAMP_W-1:0] w_diff;
    logic               w_a_older;
    logic               w_pick_a;
    logic               w_pick_b;

    assign w_to_a    = !i_id[ID_W-1] && (i_id != '0);
    assign w_diff    = i_stat_a.head_stamp - i_stat_b.head_stamp;
    assign w_a_older = w_diff[STAMP_W-1];

    always_comb begin
        w_pick_a = 1'b0;
        w_pick_b = 1'b0;
        unique case (i_mode)
            MODE_ANY: begin
                priority if (i_stat_a.have && i_stat_b.have) begin
                    w_pick_a = w_a_older;
                    w_pick_b = !w_a_older;
                end else if (i_stat_a.have) begin
                    w_pick_a = 1'b1;
                end else begin
                    w_pick_b = i_stat_b.have;
                end
            end
            MODE_A: w_pick_a = i_stat_a.have;
            MODE_B: w_pick_b = i_stat_b.have;
            default: ;
        endcase
    end

    always_comb begin
        o_ctrl_a = '0;
        o_ctrl_b = '0;
        o_status = ST_EMPTY;
        o_taken  = '0;
        if (i_func == FUNC_ENQ) begin
            if (w_to_a) begin
                o_status      = i_stat_a.full ? ST_FULL : ST_ENQUEUED;
                o_ctrl_a.push = i_go && !i_stat_a.full;
            end else begin
                o_status      = i_stat_b.full ? ST_FULL : ST_ENQUEUED;
                o_ctrl_b.push = i_go && !i_stat_b.full;
            end
        end else if (w_pick_a) begin
            o_status     = ST_DEQUEUED;
            o_taken      = i_stat_a.head_id;
            o_ctrl_a.pop = i_go;
        end else if (w_pick_b) begin
            o_status     = ST_DEQUEUED;
            o_taken      = i_stat_b.head_id;
            o_ctrl_b.pop = i_go;
        end
    end

endmodule

// ===== design/two_class_fifo_oldest_first.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake               | Payload
// in      | input     | i_in_valid / o_in_stall | i_func, i_item_id, i_take_mode
// out     | output    | o_out_valid / i_out_stall | o_status, o_taken_id
//
// Stages: input register, then queue update and result register.
// One item per cycle sustained; both stages advance together when the result
// register is empty or being taken.
// Reset (synchronous, active low) empties both queues and zeroes the stamp counter.
// An output stall backs up into o_in_stall once the input register is occupied.

module two_class_fifo_oldest_first import tcf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_func,
    input  logic signed [ID_W-1:0] i_item_id,
    input  logic [1:0]             i_take_mode,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic signed [ID_W-1:0] o_taken_id
);

`include "two_class_fifo_oldest_first_defines.svh"

    // input register
    logic               r_in_valid;
    logic               r_func;
    logic [ID_W-1:0]    r_id;
    logic [1:0]         r_mode;

    // result register
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [ID_W-1:0]    r_taken;

    // shared arrival stamp counter
    logic [STAMP_W-1:0] r_cnt;

    logic               w_advance;
    logic               w_load;
    t_q_ctrl            w_ctrl_a;
    t_q_ctrl            w_ctrl_b;
    t_q_stat            w_stat_a;
    t_q_stat            w_stat_b;
    logic [1:0]         n_status;
    logic [ID_W-1:0]    n_taken;
    logic               w_push_any;

    // the held item moves into the result register when that one frees up
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_load     = !o_in_stall;
    assign w_push_any = w_ctrl_a.push || w_ctrl_b.push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_in_valid) begin
            r_func <= i_func;
            r_id   <= i_item_id;
            r_mode <= i_take_mode;
        end
    end

    tcf_select u_select (
        .i_go     (w_advance),
        .i_func   (r_func),
        .i_id     (r_id),
        .i_mode   (r_mode),
        .i_stat_a (w_stat_a),
        .i_stat_b (w_stat_b),
        .o_ctrl_a (w_ctrl_a),
        .o_ctrl_b (w_ctrl_b),
        .o_status (n_status),
        .o_taken  (n_taken)
    );

    tcf_queue u_queue_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl_a),
        .i_id    (r_id),
        .i_stamp (r_cnt),
        .o_stat  (w_stat_a)
    );

    tcf_queue u_queue_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl_b),
        .i_id    (r_id),
        .i_stamp (r_cnt),
        .o_stat  (w_stat_b)
    );

    // counter steps only on an accepted push; dropped enqueues leave it alone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_push_any) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_status <= n_status;
            r_taken  <= n_taken;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_taken_id  = r_taken;

    // at most one queue is touched per item, and never push and pop together
    `TCF_ASSERT(a_one_queue_op, i_clk, i_rst_n, $onehot0({w_ctrl_a.push, w_ctrl_a.pop, w_ctrl_b.push, w_ctrl_b.pop}), "more than one queue operation in a cycle")
    // every push advances the stamp counter by exactly one
    `TCF_ASSERT(a_cnt_step, i_clk, i_rst_n, w_push_any |=> (r_cnt == $past(r_cnt) + 1'b1), "stamp counter did not step on push")
    // queue operations happen only when the held item moves on
    `TCF_ASSERT_ALWAYS(a_op_needs_advance, i_clk, (w_push_any || w_ctrl_a.pop || w_ctrl_b.pop) |-> w_advance, "queue changed without an item advancing")

endmodule
